// File: hdl/pbcrs_pkg.sv
// shared types and constants for the pad bus combo reset sniffer
// no dependencies; imported by every module of the block
package pbcrs_pkg;

    // frame length in bus clock edges and capture head sizes
    localparam int unsigned BIT_INDEX_W   = 7;
    localparam logic [BIT_INDEX_W-1:0] FRAME_BITS = 7'd72;
    localparam int unsigned CMD_HEAD_BITS = 16;
    localparam int unsigned DAT_HEAD_BITS = 40;

    // decode constants
    localparam logic [7:0]  CMD_POLL_0 = 8'h01;
    localparam logic [7:0]  CMD_POLL_1 = 8'h42;
    localparam logic [15:0] ID_PAD_A   = 16'h5A41;
    localparam logic [15:0] ID_PAD_B   = 16'h5A73;
    localparam logic [15:0] ID_PAD_C   = 16'h5A53;
    localparam logic [15:0] ID_GUN     = 16'h5A63;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_PAD  = 2'd1;
    localparam logic [1:0] KIND_GUN  = 2'd2;

    // configuration port
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] CFG_QUALIFY   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLDOFF   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAP       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAD_COMBO = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_GUN_COMBO = 3'd5;

    // event queue between front and back
    localparam int unsigned EVQ_DEPTH = 4;
    localparam int unsigned EVQ_AW    = 2;

    typedef enum logic [1:0] {
        PH_LISTEN  = 2'd0,
        PH_HOLD    = 2'd1,
        PH_HOLDOFF = 2'd2,
        PH_GAP     = 2'd3
    } phase_t;

    typedef struct packed {
        logic clk_level;
        logic select_level;
        logic cmd_level;
        logic data_level;
    } in_word_t;

    typedef struct packed {
        logic       reset_drive;
        logic       capture_armed;
        logic       frame_done;
        logic       frame_match;
        logic [1:0] device_kind;
    } out_word_t;

    // classified sample passed from front to back
    typedef struct packed {
        logic clk_rise;
        logic sel_fall;
        logic sel_low;
        logic cmd;
        logic dat;
    } event_t;

    typedef struct packed {
        logic [15:0] qualify_samples;
        logic [31:0] reset_hold_samples;
        logic [31:0] holdoff_samples;
        logic [31:0] gap_samples;
        logic [15:0] pad_combo;
        logic [15:0] gun_combo;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        qualify_samples:    16'd328,
        reset_hold_samples: 32'd20000000,
        holdoff_samples:    32'd20000000,
        gap_samples:        32'd1000000,
        pad_combo:          16'hFCF6,
        gun_combo:          16'h9FF7
    };

endpackage

// File: hdl/pbcrs_front.sv
// front end: keeps pin history and turns each sample into an edge event
// depends on pbcrs_pkg
module pbcrs_front
    import pbcrs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  in_word_t sample,
    output event_t   ev
);

    logic clk_prev_reg;
    logic clk_prev_next;
    logic select_prev_reg;
    logic select_prev_next;

    always_comb
    begin
        ev.clk_rise = !clk_prev_reg && sample.clk_level;
        ev.sel_fall = select_prev_reg && !sample.select_level;
        ev.sel_low  = !sample.select_level;
        ev.cmd      = sample.cmd_level;
        ev.dat      = sample.data_level;
        clk_prev_next    = accept ? sample.clk_level : clk_prev_reg;
        select_prev_next = accept ? sample.select_level : select_prev_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_prev_reg    <= 1'b0;
            select_prev_reg <= 1'b1;
        end
        else
        begin
            clk_prev_reg    <= clk_prev_next;
            select_prev_reg <= select_prev_next;
        end
    end

endmodule

// File: hdl/pbcrs_evq.sv
// short event queue that decouples the front end from the frame engine
// depends on pbcrs_pkg
module pbcrs_evq
    import pbcrs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  event_t wr_word,
    output logic   full,
    input  logic   rd_en,
    output logic   rd_valid,
    output event_t rd_word
);

    event_t mem [EVQ_DEPTH];
    logic [EVQ_AW-1:0] wr_ptr_reg;
    logic [EVQ_AW-1:0] wr_ptr_next;
    logic [EVQ_AW-1:0] rd_ptr_reg;
    logic [EVQ_AW-1:0] rd_ptr_next;
    logic [EVQ_AW:0]   count_reg;
    logic [EVQ_AW:0]   count_next;
    logic do_wr;
    logic do_rd;

    always_comb
    begin
        full     = (count_reg == (EVQ_AW+1)'(EVQ_DEPTH));
        rd_valid = (count_reg != '0);
        rd_word  = mem[rd_ptr_reg];
        do_wr    = wr_en && !full;
        do_rd    = rd_en && rd_valid;
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hdl/pbcrs_back.sv
// frame engine: qualify timer, bit capture, decode, reset/holdoff/gap phases,
// and the two-word result buffer; depends on pbcrs_pkg
module pbcrs_back
    import pbcrs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      ev_valid,
    input  event_t    ev,
    output logic      ev_pop,
    output logic      empty,
    input  logic      pop,
    output out_word_t result
);

    phase_t                   phase_reg;
    phase_t                   phase_next;
    logic [31:0]              wait_left_reg;
    logic [31:0]              wait_left_next;
    logic [15:0]              qualify_left_reg;
    logic [15:0]              qualify_left_next;
    logic                     qualify_busy_reg;
    logic                     qualify_busy_next;
    logic                     armed_reg;
    logic                     armed_next;
    logic [BIT_INDEX_W-1:0]   bit_index_reg;
    logic [BIT_INDEX_W-1:0]   bit_index_next;
    logic [CMD_HEAD_BITS-1:0] command_head_reg;
    logic [CMD_HEAD_BITS-1:0] command_head_next;
    logic [DAT_HEAD_BITS-1:0] data_head_reg;
    logic [DAT_HEAD_BITS-1:0] data_head_next;

    logic [CMD_HEAD_BITS-1:0] cmd_shift;
    logic [DAT_HEAD_BITS-1:0] dat_shift;
    logic [BIT_INDEX_W-1:0]   bit_inc;
    logic [31:0]              wait_dec;
    logic [15:0]              qualify_dec;
    logic [15:0]              frame_id;
    logic [15:0]              frame_sw;
    logic                     done;
    logic                     match;
    logic [1:0]               kind;
    out_word_t                step_word;

    // result buffer
    out_word_t obuf_mem [2];
    logic       obuf_wr_reg;
    logic       obuf_wr_next;
    logic       obuf_rd_reg;
    logic       obuf_rd_next;
    logic [1:0] obuf_count_reg;
    logic [1:0] obuf_count_next;
    logic       step;
    logic       do_pop;

    always_comb
    begin
        step   = ev_valid && (obuf_count_reg != 2'd2);
        ev_pop = step;
        empty  = (obuf_count_reg == 2'd0);
        result = obuf_mem[obuf_rd_reg];
        do_pop = pop && !empty;
        obuf_wr_next = step ? !obuf_wr_reg : obuf_wr_reg;
        obuf_rd_next = do_pop ? !obuf_rd_reg : obuf_rd_reg;
        obuf_count_next = obuf_count_reg;
        if (step && !do_pop)
        begin
            obuf_count_next = obuf_count_reg + 2'd1;
        end
        else if (do_pop && !step)
        begin
            obuf_count_next = obuf_count_reg - 2'd1;
        end
    end

    // shifted heads, one bit set at the current bit index, lsb first
    always_comb
    begin
        for (int i = 0; i < CMD_HEAD_BITS; i++)
        begin
            cmd_shift[i] = command_head_reg[i] |
                           (ev.cmd && (bit_index_reg == BIT_INDEX_W'(i)));
        end
        for (int j = 0; j < DAT_HEAD_BITS; j++)
        begin
            dat_shift[j] = data_head_reg[j] |
                           (ev.dat && (bit_index_reg == BIT_INDEX_W'(j)));
        end
    end

    always_comb
    begin
        phase_next        = phase_reg;
        wait_left_next    = wait_left_reg;
        qualify_left_next = qualify_left_reg;
        qualify_busy_next = qualify_busy_reg;
        armed_next        = armed_reg;
        bit_index_next    = bit_index_reg;
        command_head_next = command_head_reg;
        data_head_next    = data_head_reg;
        done  = 1'b0;
        match = 1'b0;
        kind  = KIND_NONE;
        bit_inc     = bit_index_reg + 1'b1;
        wait_dec    = (wait_left_reg != 32'd0) ? wait_left_reg - 32'd1 : 32'd0;
        qualify_dec = (qualify_left_reg != 16'd0) ? qualify_left_reg - 16'd1 : 16'd0;
        frame_id    = dat_shift[23:8];
        frame_sw    = dat_shift[39:24];

        case (phase_reg)
            PH_LISTEN:
            begin
                if (armed_reg && ev.clk_rise)
                begin
                    command_head_next = cmd_shift;
                    data_head_next    = dat_shift;
                    bit_index_next    = bit_inc;
                    done              = (bit_inc >= FRAME_BITS);
                end
                if (done)
                begin
                    if (cmd_shift[7:0] == CMD_POLL_0 && cmd_shift[15:8] == CMD_POLL_1)
                    begin
                        if (frame_id == ID_GUN)
                        begin
                            kind = KIND_GUN;
                        end
                        else if (frame_id == ID_PAD_A || frame_id == ID_PAD_B ||
                                 frame_id == ID_PAD_C)
                        begin
                            kind = KIND_PAD;
                        end
                    end
                    match = (kind == KIND_PAD && frame_sw == cfg.pad_combo) ||
                            (kind == KIND_GUN && frame_sw == cfg.gun_combo);
                    armed_next        = 1'b0;
                    qualify_busy_next = 1'b0;
                    qualify_left_next = 16'd0;
                    bit_index_next    = '0;
                    command_head_next = '0;
                    data_head_next    = '0;
                    if (match)
                    begin
                        phase_next     = PH_HOLD;
                        wait_left_next = cfg.reset_hold_samples;
                    end
                    else
                    begin
                        phase_next     = PH_GAP;
                        wait_left_next = cfg.gap_samples;
                    end
                end
                else if (ev.sel_fall)
                begin
                    qualify_left_next = cfg.qualify_samples;
                    qualify_busy_next = 1'b1;
                end
                else if (qualify_busy_reg)
                begin
                    qualify_left_next = qualify_dec;
                    if (qualify_dec == 16'd0)
                    begin
                        qualify_busy_next = 1'b0;
                        if (ev.sel_low)
                        begin
                            armed_next = 1'b1;
                        end
                    end
                end
            end
            PH_HOLD:
            begin
                wait_left_next = wait_dec;
                if (wait_dec == 32'd0)
                begin
                    phase_next     = PH_HOLDOFF;
                    wait_left_next = cfg.holdoff_samples;
                end
            end
            PH_HOLDOFF:
            begin
                wait_left_next = wait_dec;
                if (wait_dec == 32'd0)
                begin
                    phase_next     = PH_GAP;
                    wait_left_next = cfg.gap_samples;
                end
            end
            PH_GAP:
            begin
                wait_left_next = wait_dec;
                if (wait_dec == 32'd0)
                begin
                    phase_next = PH_LISTEN;
                end
            end
            default:
            begin
                phase_next = PH_LISTEN;
            end
        endcase

        step_word.reset_drive   = (phase_next == PH_HOLD);
        step_word.capture_armed = armed_next;
        step_word.frame_done    = done;
        step_word.frame_match   = match;
        step_word.device_kind   = kind;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            obuf_mem[obuf_wr_reg] <= step_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_LISTEN;
            wait_left_reg    <= '0;
            qualify_left_reg <= '0;
            qualify_busy_reg <= 1'b0;
            armed_reg        <= 1'b0;
            bit_index_reg    <= '0;
            command_head_reg <= '0;
            data_head_reg    <= '0;
            obuf_wr_reg      <= 1'b0;
            obuf_rd_reg      <= 1'b0;
            obuf_count_reg   <= 2'd0;
        end
        else
        begin
            if (step)
            begin
                phase_reg        <= phase_next;
                wait_left_reg    <= wait_left_next;
                qualify_left_reg <= qualify_left_next;
                qualify_busy_reg <= qualify_busy_next;
                armed_reg        <= armed_next;
                bit_index_reg    <= bit_index_next;
                command_head_reg <= command_head_next;
                data_head_reg    <= data_head_next;
            end
            obuf_wr_reg    <= obuf_wr_next;
            obuf_rd_reg    <= obuf_rd_next;
            obuf_count_reg <= obuf_count_next;
        end
    end

endmodule

// File: hdl/pad_bus_combo_reset_sniffer.sv
// each result word is written through the event queue, then the result buffer
// throughput: one sample per cycle unless the result buffer is full
// the four-entry event queue and two-word result buffer absorb pop stalls
// reset: config registers return to defaults, queues empty, engine listening,
// pin history at clock low and select high
// depends on pbcrs_pkg, pbcrs_front, pbcrs_evq, pbcrs_back
module pad_bus_combo_reset_sniffer
    import pbcrs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  in_word_t               sample,
    output logic                   empty,
    input  logic                   pop,
    output out_word_t              result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t   cfg_reg;
    cfg_t   cfg_next;
    event_t front_ev;
    event_t back_ev;
    logic   accept;
    logic   ev_valid;
    logic   ev_pop;

    assign accept = push && !full;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_QUALIFY:   cfg_next.qualify_samples    = cfg_data[15:0];
                CFG_HOLD:      cfg_next.reset_hold_samples = cfg_data;
                CFG_HOLDOFF:   cfg_next.holdoff_samples    = cfg_data;
                CFG_GAP:       cfg_next.gap_samples        = cfg_data;
                CFG_PAD_COMBO: cfg_next.pad_combo          = cfg_data[15:0];
                CFG_GUN_COMBO: cfg_next.gun_combo          = cfg_data[15:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pbcrs_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .sample (sample),
        .ev     (front_ev)
    );

    pbcrs_evq u_evq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept),
        .wr_word  (front_ev),
        .full     (full),
        .rd_en    (ev_pop),
        .rd_valid (ev_valid),
        .rd_word  (back_ev)
    );

    pbcrs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .ev_valid (ev_valid),
        .ev       (back_ev),
        .ev_pop   (ev_pop),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

    // a match always comes with a decoded frame of a known device
    a_match_has_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.frame_match) |->
            (result.frame_done && result.device_kind != KIND_NONE))
        else $error("match without a decoded known frame");

    // capture is never armed while reset is driven
    a_no_drive_while_armed: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(result.reset_drive && result.capture_armed))
        else $error("reset driven while capture armed");

    // an accepted word is waiting for the engine on the next cycle
    a_accept_reaches_queue: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ev_valid)
        else $error("accepted word missing from event queue");

    // the engine never steps without a queued event
    a_pop_needs_event: assert property (@(posedge clk) disable iff (!rst_n)
        ev_pop |-> ev_valid)
        else $error("engine stepped on an empty event queue");

endmodule

// File: bench/tb_top.sv
// self-checking bench for pad_bus_combo_reset_sniffer: pin samples in, status words out
// depends on pbcrs_pkg (hdl/pbcrs_pkg.sv) and the sniffer rtl; a local model predicts
// every status word, which is compared field by field as it is popped
module tb_top;
    import pbcrs_pkg::*;

    localparam int CYCLE_LIMIT = 6_000_000;
    localparam int RANDOM_SAMPLES = 200;
    localparam int FULL_FRAME = 72;
    localparam int MAX_REPORTS = 40;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 3'd7;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   push = 1'b0;
    logic                   full;
    in_word_t               sample = '0;
    logic                   empty;
    logic                   pop = 1'b0;
    out_word_t              result;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    pad_bus_combo_reset_sniffer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .sample    (sample),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // sniffer model state
    cfg_t         m_cfg;
    logic         m_clk_prev;
    logic         m_sel_prev;
    logic [15:0]  m_qual_left;
    logic         m_qual_busy;
    logic         m_armed;
    logic [6:0]   m_bit_idx;
    logic [15:0]  m_cmd_head;
    logic [39:0]  m_dat_head;
    phase_t       m_phase;
    logic [31:0]  m_wait_left;

    out_word_t    status_due[$];
    out_word_t    due_word;
    bit           gaps_on = 1'b1;
    int           stall_left = 0;
    int           mismatches = 0;
    int           cycles = 0;
    int           samples_sent = 0;
    int           frames_decoded = 0;
    int           resets_fired = 0;

    function automatic void sniff_clear_capture();
        m_armed = 1'b0;
        m_qual_busy = 1'b0;
        m_qual_left = '0;
        m_bit_idx = '0;
        m_cmd_head = '0;
        m_dat_head = '0;
    endfunction

    function automatic void sniff_reset();
        m_cfg = CFG_RESET;
        m_clk_prev = 1'b0;
        m_sel_prev = 1'b1;
        sniff_clear_capture();
        m_phase = PH_LISTEN;
        m_wait_left = '0;
    endfunction

    function automatic out_word_t sniff_step(input in_word_t s);
        logic        clk_rise;
        logic        sel_fall;
        logic        done;
        logic        match;
        logic [1:0]  kind;
        logic [15:0] id;
        logic [15:0] sw;
        out_word_t   w;
        clk_rise = !m_clk_prev && s.clk_level;
        sel_fall = m_sel_prev && !s.select_level;
        done = 1'b0;
        match = 1'b0;
        kind = KIND_NONE;
        if (m_phase == PH_LISTEN)
        begin
            if (m_armed && clk_rise)
            begin
                if (m_bit_idx < CMD_HEAD_BITS)
                    m_cmd_head = m_cmd_head | (16'(s.cmd_level) << m_bit_idx);
                if (m_bit_idx < DAT_HEAD_BITS)
                    m_dat_head = m_dat_head | (40'(s.data_level) << m_bit_idx);
                m_bit_idx = m_bit_idx + 7'd1;
                if (m_bit_idx >= FRAME_BITS)
                    done = 1'b1;
            end
            if (done)
            begin
                id = m_dat_head[23:8];
                sw = m_dat_head[39:24];
                if (m_cmd_head[7:0] == CMD_POLL_0 && m_cmd_head[15:8] == CMD_POLL_1)
                begin
                    if (id == ID_GUN)
                        kind = KIND_GUN;
                    else if (id == ID_PAD_A || id == ID_PAD_B || id == ID_PAD_C)
                        kind = KIND_PAD;
                end
                match = (kind == KIND_PAD && sw == m_cfg.pad_combo) ||
                        (kind == KIND_GUN && sw == m_cfg.gun_combo);
                sniff_clear_capture();
                if (match)
                begin
                    m_phase = PH_HOLD;
                    m_wait_left = m_cfg.reset_hold_samples;
                end
                else
                begin
                    m_phase = PH_GAP;
                    m_wait_left = m_cfg.gap_samples;
                end
            end
            else if (sel_fall)
            begin
                m_qual_left = m_cfg.qualify_samples;
                m_qual_busy = 1'b1;
            end
            else if (m_qual_busy)
            begin
                if (m_qual_left != 0)
                    m_qual_left = m_qual_left - 16'd1;
                if (m_qual_left == 0)
                begin
                    m_qual_busy = 1'b0;
                    if (!s.select_level)
                        m_armed = 1'b1;
                end
            end
        end
        else
        begin
            if (m_wait_left != 0)
                m_wait_left = m_wait_left - 32'd1;
            if (m_wait_left == 0)
            begin
                case (m_phase)
                    PH_HOLD:
                    begin
                        m_phase = PH_HOLDOFF;
                        m_wait_left = m_cfg.holdoff_samples;
                    end
                    PH_HOLDOFF:
                    begin
                        m_phase = PH_GAP;
                        m_wait_left = m_cfg.gap_samples;
                    end
                    default:
                    begin
                        m_phase = PH_LISTEN;
                        m_wait_left = '0;
                    end
                endcase
            end
        end
        m_clk_prev = s.clk_level;
        m_sel_prev = s.select_level;
        w.reset_drive = (m_phase == PH_HOLD);
        w.capture_armed = m_armed;
        w.frame_done = done;
        w.frame_match = match;
        w.device_kind = kind;
        return w;
    endfunction

    function automatic bit rbit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic in_word_t pin_word(input logic c, input logic s, input logic m,
                                          input logic d);
        return '{clk_level: c, select_level: s, cmd_level: m, data_level: d};
    endfunction

    // command bits of a frame, shifted out lsb first
    function automatic logic [71:0] poll_cmd(input logic [7:0] b0, input logic [7:0] b1);
        return {24'($urandom), 32'($urandom), b1, b0};
    endfunction

    // data bits: byte 0 filler, id low byte first, then switch word
    function automatic logic [71:0] poll_dat(input logic [15:0] id, input logic [15:0] sw);
        return {32'($urandom), sw, id, 8'($urandom)};
    endfunction

    task automatic send_sample(input in_word_t s);
        out_word_t w;
        if (gaps_on && $urandom_range(0, 11) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        push <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (full)
            @(posedge clk);
        w = sniff_step(s);
        status_due.push_back(w);
        samples_sent++;
        if (w.frame_done)
            frames_decoded++;
        if (w.frame_match)
            resets_fired++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
        push <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_QUALIFY:   m_cfg.qualify_samples = val[15:0];
            CFG_HOLD:      m_cfg.reset_hold_samples = val;
            CFG_HOLDOFF:   m_cfg.holdoff_samples = val;
            CFG_GAP:       m_cfg.gap_samples = val;
            CFG_PAD_COMBO: m_cfg.pad_combo = val[15:0];
            CFG_GUN_COMBO: m_cfg.gun_combo = val[15:0];
            default:       ;
        endcase
    endtask

    // random pins until the hold, holdoff and gap waits are over
    task automatic drain_wait_phases();
        while (m_phase != PH_LISTEN)
            send_sample(pin_word(rbit(), rbit(), rbit(), rbit()));
    endtask

    task automatic send_frame(input logic [71:0] cmd_bits, input logic [71:0] dat_bits,
                              input int lead, input int nbits, input int blip_bit,
                              input bit jitter);
        int lows;
        int highs;
        send_sample(pin_word(1'b0, 1'b1, rbit(), rbit()));
        for (int i = 0; i < lead; i++)
            send_sample(pin_word(1'b0, 1'b0, rbit(), rbit()));
        for (int i = 0; i < nbits; i++)
        begin
            lows = jitter ? int'($urandom_range(1, 3)) : 1;
            highs = jitter ? int'($urandom_range(1, 2)) : 1;
            // a blip raises select just before the edge, so it falls on the edge sample
            for (int k = 0; k < lows; k++)
                send_sample(pin_word(1'b0, (i == blip_bit) && (k == lows - 1), rbit(), rbit()));
            for (int k = 0; k < highs; k++)
                send_sample(pin_word(1'b1, 1'b0, cmd_bits[i], dat_bits[i]));
        end
        drain_wait_phases();
    endtask

    function automatic int arm_lead();
        return int'(m_cfg.qualify_samples) + 1;
    endfunction

    task automatic send_random_frame(input bit whole);
        logic [15:0] id;
        logic [15:0] sw;
        logic [7:0]  b0;
        logic [7:0]  b1;
        case ($urandom_range(0, 4))
            0:       id = ID_PAD_A;
            1:       id = ID_PAD_B;
            2:       id = ID_PAD_C;
            3:       id = ID_GUN;
            default: id = 16'($urandom);
        endcase
        if ($urandom_range(0, 2) != 0)
            sw = (id == ID_GUN) ? m_cfg.gun_combo : m_cfg.pad_combo;
        else
            sw = 16'($urandom);
        b0 = ($urandom_range(0, 9) != 0) ? CMD_POLL_0 : 8'($urandom);
        b1 = ($urandom_range(0, 9) != 0) ? CMD_POLL_1 : 8'($urandom);
        send_frame(poll_cmd(b0, b1), poll_dat(id, sw), arm_lead() + int'($urandom_range(0, 3)),
                   whole ? FULL_FRAME : int'($urandom_range(1, 71)),
                   ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 71)) : -1, rbit());
    endtask

    task automatic shuffle_settings();
        write_reg(CFG_QUALIFY, $urandom_range(0, 6));
        write_reg(CFG_HOLD, $urandom_range(0, 5));
        write_reg(CFG_HOLDOFF, $urandom_range(0, 5));
        write_reg(CFG_GAP, $urandom_range(0, 5));
        write_reg(CFG_PAD_COMBO, ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom);
        write_reg(CFG_GUN_COMBO, ($urandom_range(0, 3) == 0) ? 32'hFFFF : $urandom);
    endtask

    // reset values: a select fall starts the long default qualify timer
    task automatic test_defaults();
        send_sample(pin_word(1'b0, 1'b1, 1'b0, 1'b0));
        send_sample(pin_word(1'b1, 1'b1, 1'b1, 1'b1));
        send_sample(pin_word(1'b0, 1'b0, 1'b1, 1'b0));
        send_sample(pin_word(1'b1, 1'b0, 1'b0, 1'b1));
        send_sample(pin_word(1'b0, 1'b1, 1'b0, 1'b0));
        send_sample(pin_word(1'b1, 1'b1, 1'b1, 1'b1));
    endtask

    // upper data bits are dropped on narrow registers, spare indexes do nothing
    task automatic test_register_writes();
        write_reg(CFG_QUALIFY, 32'hABCD_0002);
        write_reg(CFG_HOLD, 32'd3);
        write_reg(CFG_HOLDOFF, 32'd2);
        write_reg(CFG_GAP, 32'd1);
        write_reg(CFG_PAD_COMBO, 32'h1234_FCF6);
        write_reg(CFG_GUN_COMBO, 32'h0000_9FF7);
        write_reg(CFG_SPARE_A, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_B, 32'h0000_0000);
        send_sample(pin_word(1'b0, 1'b1, 1'b1, 1'b0));
        send_sample(pin_word(1'b1, 1'b1, 1'b0, 1'b1));
    endtask

    task automatic test_poll_frames();
        send_frame(poll_cmd(CMD_POLL_0, CMD_POLL_1), poll_dat(ID_PAD_A, m_cfg.pad_combo),
                   arm_lead(), FULL_FRAME, -1, 1'b0);
        send_frame(poll_cmd(CMD_POLL_0, CMD_POLL_1), poll_dat(ID_PAD_C, m_cfg.pad_combo),
                   arm_lead(), FULL_FRAME, -1, 1'b1);
        send_frame(poll_cmd(CMD_POLL_0, CMD_POLL_1), poll_dat(ID_GUN, m_cfg.gun_combo),
                   arm_lead(), FULL_FRAME, -1, 1'b0);
        send_frame(poll_cmd(CMD_POLL_0, CMD_POLL_1), poll_dat(ID_PAD_A, m_cfg.pad_combo ^ 16'h1),
                   arm_lead(), FULL_FRAME, -1, 1'b0);
        send_frame(poll_cmd(CMD_POLL_0, CMD_POLL_1), poll_dat(ID_GUN, m_cfg.pad_combo),
                   arm_lead(), FULL_FRAME, -1, 1'b0);
        send_frame(poll_cmd(8'h81, CMD_POLL_1), poll_dat(ID_PAD_A, m_cfg.pad_combo),
                   arm_lead(), FULL_FRAME, -1, 1'b0);
        send_frame(poll_cmd(CMD_POLL_0, 8'h43), poll_dat(ID_PAD_B, m_cfg.pad_combo),
                   arm_lead(), FULL_FRAME, -1, 1'b0);
    endtask

    task automatic test_corner_cases();
        // select back high before the qualify timer runs out
        write_reg(CFG_QUALIFY, 32'd3);
        send_sample(pin_word(1'b0, 1'b1, 1'b0, 1'b1));
        send_sample(pin_word(1'b0, 1'b0, 1'b1, 1'b0));
        send_sample(pin_word(1'b0, 1'b0, 1'b0, 1'b1));
        send_sample(pin_word(1'b0, 1'b1, 1'b1, 1'b0));
        send_sample(pin_word(1'b1, 1'b1, 1'b0, 1'b1));
        send_sample(pin_word(1'b0, 1'b1, 1'b1, 1'b1));
        send_sample(pin_word(1'b1, 1'b1, 1'b0, 1'b0));
        // clock edge on the very sample that arms capture is not taken
        write_reg(CFG_QUALIFY, 32'd2);
        send_sample(pin_word(1'b0, 1'b1, 1'b0, 1'b0));
        send_sample(pin_word(1'b0, 1'b0, 1'b1, 1'b1));
        send_sample(pin_word(1'b0, 1'b0, 1'b0, 1'b0));
        send_sample(pin_word(1'b1, 1'b0, 1'b1, 1'b1));
        // zero qualify and one-sample waits, capture already armed from above
        write_reg(CFG_QUALIFY, 32'd0);
        write_reg(CFG_HOLD, 32'd0);
        write_reg(CFG_HOLDOFF, 32'd0);
        write_reg(CFG_GAP, 32'd0);
        send_frame(poll_cmd(CMD_POLL_0, CMD_POLL_1), poll_dat(ID_GUN, m_cfg.gun_combo),
                   arm_lead(), FULL_FRAME, -1, 1'b0);
        // combo of zero against an all-zero switch word
        write_reg(CFG_PAD_COMBO, 32'd0);
        send_frame(poll_cmd(CMD_POLL_0, CMD_POLL_1), poll_dat(ID_PAD_B, 16'h0000),
                   arm_lead(), FULL_FRAME, -1, 1'b0);
        // select fall while armed reloads the timer; on the last edge the frame wins
        write_reg(CFG_QUALIFY, 32'd4);
        write_reg(CFG_GAP, 32'd2);
        send_frame(poll_cmd(CMD_POLL_0, CMD_POLL_1), poll_dat(ID_PAD_C, 16'h0000),
                   arm_lead(), FULL_FRAME, 30, 1'b0);
        send_frame(poll_cmd(CMD_POLL_0, CMD_POLL_1), poll_dat(ID_PAD_A, 16'h0000),
                   arm_lead(), FULL_FRAME, FULL_FRAME - 1, 1'b1);
    endtask

    task automatic test_extreme_settings();
        write_reg(CFG_GUN_COMBO, 32'hFFFF);
        write_reg(CFG_HOLD, 32'd1);
        write_reg(CFG_HOLDOFF, 32'd0);
        send_frame(poll_cmd(CMD_POLL_0, CMD_POLL_1), poll_dat(ID_GUN, 16'hFFFF),
                   arm_lead(), FULL_FRAME, -1, 1'b0);
        write_reg(CFG_QUALIFY, 32'hFFFF);
        write_reg(CFG_HOLD, 32'hFFFF_FFFF);
        write_reg(CFG_HOLDOFF, 32'hFFFF_FFFF);
        write_reg(CFG_GAP, 32'hFFFF_FFFF);
        write_reg(CFG_PAD_COMBO, 32'hFFFF);
        // qualify is full scale, so nothing can arm in these few samples
        repeat (12) send_sample(pin_word(rbit(), rbit(), rbit(), rbit()));
        write_reg(CFG_QUALIFY, 32'd1);
        write_reg(CFG_HOLD, 32'd2);
        write_reg(CFG_HOLDOFF, 32'd1);
        write_reg(CFG_GAP, 32'd1);
    endtask

    task automatic test_random_traffic();
        int start;
        int seq;
        int n;
        start = samples_sent;
        seq = 0;
        while (samples_sent - start < RANDOM_SAMPLES)
        begin
            if (seq % 8 == 0)
                shuffle_settings();
            seq++;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: send_random_frame(1'b1);
                6:
                begin
                    // select released before the timer expires
                    send_sample(pin_word(1'b0, 1'b1, rbit(), rbit()));
                    n = $urandom_range(0, m_cfg.qualify_samples);
                    repeat (n) send_sample(pin_word(rbit(), 1'b0, rbit(), rbit()));
                    repeat (4) send_sample(pin_word(rbit(), 1'b1, rbit(), rbit()));
                    drain_wait_phases();
                end
                7: send_random_frame(1'b0);
                default:
                begin
                    n = $urandom_range(4, 30);
                    repeat (n) send_sample(pin_word(rbit(), rbit(), rbit(), rbit()));
                    drain_wait_phases();
                end
            endcase
        end
    endtask

    task automatic test_steady_stream();
        gaps_on = 1'b0;
        shuffle_settings();
        send_random_frame(1'b1);
    endtask

    task automatic check_field(input string field, input logic [1:0] want,
                               input logic [1:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
        end
    endtask

    // pops status words with random stalls and checks each against the model
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (status_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected word, expected none actual %h", $time, result);
            end
            else
            begin
                due_word = status_due.pop_front();
                check_field("reset_drive", due_word.reset_drive, result.reset_drive);
                check_field("capture_armed", due_word.capture_armed, result.capture_armed);
                check_field("frame_done", due_word.frame_done, result.frame_done);
                check_field("frame_match", due_word.frame_match, result.frame_match);
                check_field("device_kind", due_word.device_kind, result.device_kind);
            end
        end
        if (stall_left != 0)
        begin
            stall_left--;
            pop <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 11) == 0)
        begin
            stall_left = $urandom_range(1, 18) - 1;
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding", cycles,
                     status_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        sniff_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_defaults();
        test_register_writes();
        test_poll_frames();
        test_corner_cases();
        test_extreme_settings();
        test_random_traffic();
        test_steady_stream();
        push <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        $display("covered %0d samples, %0d decoded frames, %0d reset pulses, %0d mismatches",
                 samples_sent, frames_decoded, resets_fired, mismatches);
        $display("settings ran from reset values through zero and full-scale waits and combos");
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
